>>> src/feedforward_audio_compressor_unit_macros.svh
// Assertion macros shared by the compressor RTL.
// Relies on i_clk and i_rst_n being in scope where a macro is used.
`ifndef FEEDFORWARD_AUDIO_COMPRESSOR_UNIT_MACROS_SVH
`define FEEDFORWARD_AUDIO_COMPRESSOR_UNIT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define FAC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define FAC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/fac_pkg.sv
// Package for the feedforward audio compressor: widths, item and config types,
// datapath op codes and the microcode program. No dependencies.
`timescale 1ns / 1ps

package fac_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int Q_W         = 24;   // Q1.23 level / gain width
    localparam int RATIO_W     = 16;
    localparam int DEPTH_W     = 16;
    localparam int COEF_W      = 25;   // Q1.24 coefficient incl. 1.0
    localparam int ENV_W       = 26;   // Q3.23 envelope
    localparam int CFG_DATA_W  = 25;
    localparam int CFG_IDX_W   = 3;

    localparam int MUL_A_W = ((SAMPLE_BITS > ENV_W) ? SAMPLE_BITS : ENV_W) + 1;
    localparam int MUL_B_W = COEF_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam logic [Q_W-1:0]    ONE_Q23    = Q_W'(1) << 23;
    localparam logic [COEF_W-1:0] ONE_Q24    = COEF_W'(1) << 24;
    localparam logic [ENV_W-1:0]  MAX_SCALED = ENV_W'(1) << 25;

    localparam logic [23:0] THRESHOLD_RST = 24'd4278190;
    localparam logic [15:0] RATIO_RST     = 16'd10240;
    localparam logic [15:0] DEPTH_RST     = 16'd47186;
    localparam logic [23:0] FLOOR_RST     = 24'd4194304;
    localparam logic [24:0] ATTACK_RST    = 25'd16777;
    localparam logic [24:0] RELEASE_RST   = 25'd1678;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD = 3'd0,
        REG_RATIO     = 3'd1,
        REG_DEPTH     = 3'd2,
        REG_FLOOR     = 3'd3,
        REG_ATTACK    = 3'd4,
        REG_RELEASE   = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic                          block_end_in;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic [Q_W-1:0]                gain_applied;
        logic                          block_end_out;
    } t_out_item;

    // Config as seen by the datapath: floor and coefficients already clamped.
    typedef struct packed {
        logic [Q_W-1:0]     threshold;
        logic [RATIO_W-1:0] ratio_gain;
        logic [DEPTH_W-1:0] reduction_depth;
        logic [Q_W-1:0]     floor_gain;
        logic [COEF_W-1:0]  attack_coeff;
        logic [COEF_W-1:0]  release_coeff;
    } t_cfg;

    typedef enum logic [3:0] {
        OP_LOAD,
        OP_EXCESS,
        OP_MUL_RATIO,
        OP_SCALE,
        OP_MUL_COEF,
        OP_ENV,
        OP_MUL_DEPTH,
        OP_GAIN,
        OP_MUL_OUT,
        OP_EMIT
    } t_dp_op;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_WAIT_IN,
        JMP_WAIT_OUT
    } t_jmp;

    localparam int UPC_W = 4;
    typedef logic [UPC_W-1:0] t_upc;
    localparam t_upc UPC_LAST = t_upc'(9);

    typedef struct packed {
        t_dp_op op;
        t_jmp   jmp;
        t_upc   target;
    } t_uop;

    typedef struct packed {
        logic in_go;
        logic out_free;
    } t_cond;

    // Microcode program: one word per step.
    function automatic t_uop ucode_rom(input t_upc addr);
        t_uop w;
        w = '{op: OP_LOAD, jmp: JMP_WAIT_IN, target: t_upc'(1)};
        unique case (addr)
            4'd0: w = '{op: OP_LOAD,      jmp: JMP_WAIT_IN,  target: t_upc'(1)};
            4'd1: w = '{op: OP_EXCESS,    jmp: JMP_NEXT,     target: t_upc'(0)};
            4'd2: w = '{op: OP_MUL_RATIO, jmp: JMP_NEXT,     target: t_upc'(0)};
            4'd3: w = '{op: OP_SCALE,     jmp: JMP_NEXT,     target: t_upc'(0)};
            4'd4: w = '{op: OP_MUL_COEF,  jmp: JMP_NEXT,     target: t_upc'(0)};
            4'd5: w = '{op: OP_ENV,       jmp: JMP_NEXT,     target: t_upc'(0)};
            4'd6: w = '{op: OP_MUL_DEPTH, jmp: JMP_NEXT,     target: t_upc'(0)};
            4'd7: w = '{op: OP_GAIN,      jmp: JMP_NEXT,     target: t_upc'(0)};
            4'd8: w = '{op: OP_MUL_OUT,   jmp: JMP_NEXT,     target: t_upc'(0)};
            4'd9: w = '{op: OP_EMIT,      jmp: JMP_WAIT_OUT, target: t_upc'(0)};
            default: w = '{op: OP_LOAD, jmp: JMP_WAIT_IN, target: t_upc'(1)};
        endcase
        return w;
    endfunction

endpackage

>>> src/fac_cfg.sv
// Configuration register file of the compressor, with clamping of floor and
// coefficients. Depends on fac_pkg.
`timescale 1ns / 1ps

module fac_cfg
    import fac_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    logic [Q_W-1:0]     r_threshold;
    logic [RATIO_W-1:0] r_ratio;
    logic [DEPTH_W-1:0] r_depth;
    logic [Q_W-1:0]     r_floor;
    logic [COEF_W-1:0]  r_attack;
    logic [COEF_W-1:0]  r_release;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
            r_ratio     <= RATIO_RST;
            r_depth     <= DEPTH_RST;
            r_floor     <= FLOOR_RST;
            r_attack    <= ATTACK_RST;
            r_release   <= RELEASE_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_THRESHOLD: r_threshold <= i_cfg_data[Q_W-1:0];
                REG_RATIO:     r_ratio     <= i_cfg_data[RATIO_W-1:0];
                REG_DEPTH:     r_depth     <= i_cfg_data[DEPTH_W-1:0];
                REG_FLOOR:     r_floor     <= i_cfg_data[Q_W-1:0];
                REG_ATTACK:    r_attack    <= i_cfg_data[COEF_W-1:0];
                REG_RELEASE:   r_release   <= i_cfg_data[COEF_W-1:0];
                default: ;     // unknown index: ignored
            endcase
        end
    end

    always_comb begin
        o_cfg.threshold       = r_threshold;
        o_cfg.ratio_gain      = r_ratio;
        o_cfg.reduction_depth = r_depth;
        o_cfg.floor_gain      = (r_floor > ONE_Q23) ? ONE_Q23 : r_floor;
        o_cfg.attack_coeff    = (r_attack > ONE_Q24) ? ONE_Q24 : r_attack;
        o_cfg.release_coeff   = (r_release > ONE_Q24) ? ONE_Q24 : r_release;
    end

endmodule

>>> src/fac_useq.sv
// Microcode sequencer: step counter, program ROM and conditional jumps.
// Depends on fac_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "feedforward_audio_compressor_unit_macros.svh"

module fac_useq
    import fac_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cond i_cond,
    output t_uop  o_uop
);

    t_upc r_upc;
    t_upc n_upc;
    t_uop uop;

    assign uop   = ucode_rom(r_upc);
    assign o_uop = uop;

    always_comb begin
        n_upc = r_upc;
        unique case (uop.jmp)
            JMP_NEXT:     n_upc = r_upc + t_upc'(1);
            JMP_WAIT_IN:  n_upc = i_cond.in_go ? uop.target : r_upc;
            JMP_WAIT_OUT: n_upc = i_cond.out_free ? uop.target : r_upc;
            default:      n_upc = r_upc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= '0;
        end else begin
            r_upc <= n_upc;
        end
    end

    `FAC_ASSERT_ALWAYS(a_upc_in_program, r_upc <= UPC_LAST, "step counter left the program")

endmodule

>>> src/fac_dpath.sv
// Compressor datapath: operand muxes, one shared multiplier, envelope state
// and output register. Driven by the microcode word. Depends on fac_pkg, macros.
`timescale 1ns / 1ps
`include "feedforward_audio_compressor_unit_macros.svh"

module fac_dpath
    import fac_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_uop      i_uop,
    input  t_cfg      i_cfg,
    input  logic      i_in_valid,
    input  t_in_item  i_in_item,
    output logic      o_in_stall,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item,
    output t_cond     o_cond
);

    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic                          r_block_end;
    logic [ENV_W-1:0]              r_acc;     // excess, then |x - env|
    logic                          r_rise;
    logic [ENV_W-1:0]              r_env;
    logic [Q_W-1:0]                r_gain;
    logic signed [PROD_W-1:0]      r_prod;
    logic                          r_out_valid;
    t_out_item                     r_out_item;

    logic                          in_go;
    logic                          out_free;
    logic [SAMPLE_BITS-1:0]        mag;
    logic [SAMPLE_BITS+23:0]       mag_wide;
    logic [Q_W-1:0]                mag_q23;
    logic [Q_W-1:0]                excess;
    logic [PROD_W-13:0]            scaled_raw;
    logic [ENV_W-1:0]              x_val;
    logic [ENV_W-1:0]              delta;
    logic [Q_W-1:0]                level;
    logic [Q_W-1:0]                reduction;
    logic [Q_W-1:0]                gain_raw;
    logic signed [PROD_W-1:0]      rounded;
    logic signed [MUL_A_W-1:0]     mul_a;
    logic signed [MUL_B_W-1:0]     mul_b;
    logic signed [PROD_W-1:0]      n_prod;

    assign in_go           = i_in_valid && (i_uop.op == OP_LOAD);
    assign out_free        = !r_out_valid || !i_out_stall;
    assign o_in_stall      = (i_uop.op != OP_LOAD);
    assign o_cond.in_go    = in_go;
    assign o_cond.out_free = out_free;
    assign o_out_valid     = r_out_valid;
    assign o_out_item      = r_out_item;

    // Rectify and align to Q1.23; most negative sample gives exactly 1.0.
    assign mag      = r_sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-r_sample)
                                              : SAMPLE_BITS'(r_sample);
    assign mag_wide = {mag, 24'b0};
    assign mag_q23  = mag_wide[SAMPLE_BITS+23:SAMPLE_BITS];
    assign excess   = (mag_q23 > i_cfg.threshold) ? (mag_q23 - i_cfg.threshold) : '0;

    // Scaled excess, saturated at 4.0.
    assign scaled_raw = r_prod[PROD_W-1:12];
    assign x_val      = (scaled_raw > (PROD_W-12)'(MAX_SCALED)) ? MAX_SCALED
                                                                : scaled_raw[ENV_W-1:0];

    assign delta     = r_prod[24+ENV_W-1:24];
    assign level     = (r_env > ENV_W'(ONE_Q23)) ? ONE_Q23 : r_env[Q_W-1:0];
    assign reduction = r_prod[16+Q_W-1:16];
    assign gain_raw  = ONE_Q23 - reduction;
    assign rounded   = r_prod + (PROD_W'(1) <<< 22);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_uop.op)
            OP_MUL_RATIO: begin
                mul_a = $signed(MUL_A_W'(r_acc));
                mul_b = $signed(MUL_B_W'(i_cfg.ratio_gain));
            end
            OP_MUL_COEF: begin
                mul_a = $signed(MUL_A_W'(r_acc));
                mul_b = $signed(MUL_B_W'(r_rise ? i_cfg.attack_coeff
                                                : i_cfg.release_coeff));
            end
            OP_MUL_DEPTH: begin
                mul_a = $signed(MUL_A_W'(level));
                mul_b = $signed(MUL_B_W'(i_cfg.reduction_depth));
            end
            OP_MUL_OUT: begin
                mul_a = MUL_A_W'(r_sample);
                mul_b = $signed(MUL_B_W'(r_gain));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign n_prod = mul_a * mul_b;

    // Working registers, no reset needed.
    always_ff @(posedge i_clk) begin
        unique case (i_uop.op)
            OP_LOAD: begin
                if (in_go) begin
                    r_sample    <= i_in_item.sample_in;
                    r_block_end <= i_in_item.block_end_in;
                end
            end
            OP_EXCESS: r_acc <= ENV_W'(excess);
            OP_SCALE: begin
                r_rise <= (x_val > r_env);
                r_acc  <= (x_val > r_env) ? (x_val - r_env) : (r_env - x_val);
            end
            OP_GAIN: r_gain <= (gain_raw < i_cfg.floor_gain) ? i_cfg.floor_gain : gain_raw;
            OP_MUL_RATIO, OP_MUL_COEF, OP_MUL_DEPTH, OP_MUL_OUT: r_prod <= n_prod;
            default: ;
        endcase
    end

    // Envelope state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_env       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_uop.op == OP_ENV) begin
                r_env <= r_rise ? (r_env + delta) : (r_env - delta);
            end
            if (i_uop.op == OP_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_uop.op == OP_EMIT && out_free) begin
            r_out_item.sample_out    <= rounded[SAMPLE_BITS+22:23];
            r_out_item.gain_applied  <= r_gain;
            r_out_item.block_end_out <= r_block_end;
        end
    end

    `FAC_ASSERT_ALWAYS(a_env_bounded, r_env <= MAX_SCALED, "envelope above 4.0")
    `FAC_ASSERT_ALWAYS(a_gain_bounded, !r_out_valid || (r_out_item.gain_applied <= ONE_Q23), "gain above unity")
    `FAC_ASSERT_NEXT(a_sign_kept, (i_uop.op == OP_EMIT) && out_free, (r_out_item.sample_out == '0) || (r_out_item.sample_out[SAMPLE_BITS-1] == r_sample[SAMPLE_BITS-1]), "output sign flipped")

endmodule

>>> src/feedforward_audio_compressor_unit.sv
// Top level of the feedforward audio compressor / limiter.
// Instantiates fac_cfg, fac_useq and fac_dpath; depends on fac_pkg.
`timescale 1ns / 1ps
//
//   channel  | handshake                    | payload
//   ---------+------------------------------+----------------------------
//   input    | i_in_valid  / o_in_stall     | i_in_item  (t_in_item)
//   output   | o_out_valid / i_out_stall    | o_out_item (t_out_item)
//   config   | i_cfg_we (no back-pressure)  | i_cfg_idx, i_cfg_data
//
// The 10-step microcode program runs one step per cycle unless it waits on
// input or output, and uses a single shared multiplier four times per item.
// The result is registered at the emit step; a new item is taken only back
// at step 0, once the emit is done.
// A stalled output holds the sequencer on its emit step; input stall stays
// high until the emit completes. Synchronous active-low reset clears the
// envelope, the config registers to their defaults and the step counter.

module feedforward_audio_compressor_unit
    import fac_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input items
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    // result items
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg  cfg;     // clamped register values
    t_uop  uop;     // current control word
    t_cond cond;    // jump conditions back to the sequencer

    fac_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Step counter + program ROM; waits on input at step 0, on output at emit.
    fac_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cond  (cond),
        .o_uop   (uop)
    );

    // Rectify, threshold, scale, envelope, gain, apply: one datapath with one
    // multiplier, sequenced by the control word.
    fac_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_uop       (uop),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .o_cond      (cond)
    );

endmodule

>>> dv/feedforward_audio_compressor_unit_checker.sv
// Checker for the feedforward audio compressor: watches the config port and both
// item channels, predicts each result and compares it. Depends on fac_pkg.
`timescale 1ns / 1ps

module feedforward_audio_compressor_unit_checker
    import fac_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_in_item              i_in_item,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_out_item             i_out_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam logic [63:0] UNITY_Q23  = 64'd1 << 23;
    localparam logic [63:0] COEF_UNITY = 64'd1 << 24;
    localparam logic [63:0] SCALED_CAP = 64'd1 << 25;
    localparam logic [63:0] ROUND_HALF = 64'd1 << 22;

    // shadow of the register file and the envelope
    logic [23:0] threshold_q;
    logic [15:0] ratio_q;
    logic [15:0] depth_q;
    logic [23:0] floor_q;
    logic [24:0] attack_q;
    logic [24:0] release_q;
    logic [25:0] envelope_q;

    t_out_item gain_reduced_q[$];
    int        fail_cnt = 0;

    function automatic logic [63:0] clamp_coef(input logic [24:0] k);
        return (64'(k) > COEF_UNITY) ? COEF_UNITY : 64'(k);
    endfunction

    // One compressor step; advances the envelope shadow.
    function automatic t_out_item compress_sample(input t_in_item it);
        logic signed [63:0] s;
        logic signed [63:0] prod;
        logic signed [63:0] q;
        logic [63:0]        mag;
        logic [63:0]        excess;
        logic [63:0]        x;
        logic [63:0]        env;
        logic [63:0]        level;
        logic [63:0]        gain;
        logic [63:0]        fl;
        t_out_item          r;
        s   = $signed(it.sample_in);
        mag = (s < 0) ? 64'(-s) : 64'(s);
        if (SAMPLE_BITS >= 24)
            mag = mag >> (SAMPLE_BITS - 24);
        else
            mag = mag << (24 - SAMPLE_BITS);
        excess = (mag > 64'(threshold_q)) ? (mag - 64'(threshold_q)) : 64'd0;
        x = (excess * 64'(ratio_q)) >> 12;
        if (x > SCALED_CAP)
            x = SCALED_CAP;
        env = 64'(envelope_q);
        if (x > env)
            env = env + ((clamp_coef(attack_q) * (x - env)) >> 24);
        else
            env = env - ((clamp_coef(release_q) * (env - x)) >> 24);
        envelope_q = env[25:0];
        env   = 64'(envelope_q);
        level = (env > UNITY_Q23) ? UNITY_Q23 : env;
        gain  = UNITY_Q23 - ((level * 64'(depth_q)) >> 16);
        fl    = (64'(floor_q) > UNITY_Q23) ? UNITY_Q23 : 64'(floor_q);
        if (gain < fl)
            gain = fl;
        prod = s * $signed(gain) + $signed(ROUND_HALF);
        q    = prod >>> 23;     // floor division, same as round half up
        r.sample_out    = q[SAMPLE_BITS-1:0];
        r.gain_applied  = gain[23:0];
        r.block_end_out = it.block_end_in;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        fail_cnt++;
        o_fail_count = fail_cnt;
        $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            threshold_q = THRESHOLD_RST;
            ratio_q     = RATIO_RST;
            depth_q     = DEPTH_RST;
            floor_q     = FLOOR_RST;
            attack_q    = ATTACK_RST;
            release_q   = RELEASE_RST;
            envelope_q  = '0;
            gain_reduced_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_THRESHOLD: threshold_q = i_cfg_data[23:0];
                    REG_RATIO:     ratio_q     = i_cfg_data[15:0];
                    REG_DEPTH:     depth_q     = i_cfg_data[15:0];
                    REG_FLOOR:     floor_q     = i_cfg_data[23:0];
                    REG_ATTACK:    attack_q    = i_cfg_data[24:0];
                    REG_RELEASE:   release_q   = i_cfg_data[24:0];
                    default: ;     // unmapped index, write dropped
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (gain_reduced_q.size() == 0) begin
                    report_mismatch("unexpected result item", 64'(i_out_item), 64'd0);
                end else begin
                    want = gain_reduced_q.pop_front();
                    if (i_out_item.sample_out !== want.sample_out)
                        report_mismatch("sample_out", 64'(i_out_item.sample_out),
                                        64'(want.sample_out));
                    if (i_out_item.gain_applied !== want.gain_applied)
                        report_mismatch("gain_applied", 64'(i_out_item.gain_applied),
                                        64'(want.gain_applied));
                    if (i_out_item.block_end_out !== want.block_end_out)
                        report_mismatch("block_end_out", 64'(i_out_item.block_end_out),
                                        64'(want.block_end_out));
                end
            end
            if (i_in_valid && !i_in_stall)
                gain_reduced_q.push_back(compress_sample(i_in_item));
        end
        o_pending = gain_reduced_q.size();
    end

endmodule

>>> dv/feedforward_audio_compressor_unit_tb.sv
// Testbench top for the feedforward audio compressor: clock, reset, config writes,
// sample stimulus and receiver stalls. Depends on fac_pkg, the RTL and the checker.
`timescale 1ns / 1ps

module feedforward_audio_compressor_unit_tb;
    import fac_pkg::*;

    localparam int CLK_HALF_NS     = 6;
    localparam int RESET_CYCLES    = 9;
    localparam int TIMEOUT_NS      = 5_000_000;   // several times the slowest run
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int END_SLACK       = 20;
    localparam int RANDOM_PHASES   = 9;
    localparam int PHASE_ITEMS     = 60;
    localparam int FULL_SCALE      = 1 << (SAMPLE_BITS - 1);

    localparam logic [CFG_DATA_W-1:0] Q23_ONE    = CFG_DATA_W'(1) << 23;
    localparam logic [CFG_DATA_W-1:0] COEF_ONE   = CFG_DATA_W'(1) << 24;
    localparam logic [CFG_DATA_W-1:0] COEF_MAX   = '1;
    localparam logic [CFG_DATA_W-1:0] Q23_MAX    = CFG_DATA_W'(24'hFF_FFFF);
    localparam logic [CFG_DATA_W-1:0] U16_MAX    = CFG_DATA_W'(16'hFFFF);
    // indexes past the register file; writes to them must be dropped
    localparam logic [CFG_IDX_W-1:0]  IDX_SPARE_LO = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0]  IDX_SPARE_HI = CFG_IDX_W'(7);

    // sample level classes for bursts of stimulus
    typedef enum int {
        LVL_RANDOM,
        LVL_LOUD,
        LVL_QUIET,
        LVL_NEAR_THR,
        LVL_EXTREME
    } t_level;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    t_in_item              in_item;
    logic                  out_valid;
    logic                  out_stall;
    t_out_item             out_item;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;

    // stimulus-side knobs read by the stall process and make_item
    bit                    steady_flow   = 1'b0;   // no idling on either side
    bit                    long_hold_req = 1'b0;   // receiver holds off for a long stretch
    logic [23:0]           cur_threshold = THRESHOLD_RST;

    always #(CLK_HALF_NS) clk = ~clk;

    feedforward_audio_compressor_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    feedforward_audio_compressor_unit_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_flow) return 0;
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_in_item make_item(input t_level lvl);
        int       mag;
        int       base;
        bit       neg;
        t_in_item it;
        neg = $urandom_range(0, 1);
        mag = 0;
        case (lvl)
            LVL_LOUD:  mag = $urandom_range(FULL_SCALE - FULL_SCALE / 4, FULL_SCALE);
            LVL_QUIET: mag = $urandom_range(0, 4096);
            LVL_NEAR_THR: begin
                base = (cur_threshold > FULL_SCALE) ? FULL_SCALE : int'(cur_threshold);
                mag  = base + $urandom_range(0, 64) - 32;
                if (mag < 0) mag = 0;
                if (mag > FULL_SCALE) mag = FULL_SCALE;
            end
            LVL_EXTREME: begin
                case ($urandom_range(0, 3))
                    0: mag = 0;
                    1: mag = 1;
                    default: mag = FULL_SCALE;
                endcase
            end
            default: mag = 0;
        endcase
        // +1.0 does not exist; the top positive code stands in for it
        if (!neg && mag == FULL_SCALE) mag = FULL_SCALE - 1;
        it.sample_in = neg ? SAMPLE_BITS'(-mag) : SAMPLE_BITS'(mag);
        if (lvl == LVL_RANDOM) it.sample_in = SAMPLE_BITS'($urandom);
        it.block_end_in = ($urandom_range(0, 7) == 0);
        return it;
    endfunction

    // Offer one item after a random gap and hold it until accepted.
    // valid stays high into the next item when no gap follows.
    task automatic send_item(input t_in_item it);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] s, input logic last);
        t_in_item it;
        it.sample_in    = s;
        it.block_end_in = last;
        send_item(it);
    endtask

    // Stop offering and wait until every expected result has come out.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // Register write; callers make sure the block is idle.
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        if (idx == REG_THRESHOLD) cur_threshold = data[23:0];
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_q23_level();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return Q23_ONE;
            2: return Q23_MAX;
            default: return CFG_DATA_W'($urandom_range(0, 1 << 23));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_u16();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return U16_MAX;
            default: return CFG_DATA_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_coef();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return COEF_ONE;
            2: return COEF_MAX;
            3, 4: return CFG_DATA_W'($urandom_range(0, 1 << 16));
            default: return CFG_DATA_W'($urandom_range(0, 1 << 24));
        endcase
    endfunction

    task automatic random_config();
        set_reg(REG_THRESHOLD, pick_q23_level());
        set_reg(REG_RATIO,     pick_u16());
        set_reg(REG_DEPTH,     pick_u16());
        set_reg(REG_FLOOR,     pick_q23_level());
        set_reg(REG_ATTACK,    pick_coef());
        set_reg(REG_RELEASE,   pick_coef());
        if ($urandom_range(0, 2) == 0)
            set_reg($urandom_range(0, 1) ? IDX_SPARE_HI : IDX_SPARE_LO,
                    CFG_DATA_W'($urandom));
    endtask

    // Receiver: random stall bursts, a counted long hold on request,
    // and no stalls at all while steady_flow is set.
    initial begin
        int hold_left;
        int stall_left;
        int run_left;
        bit hold_taken;
        hold_left  = 0;
        stall_left = 0;
        run_left   = 0;
        hold_taken = 1'b0;
        out_stall  = 1'b0;
        forever begin
            @(negedge clk);
            if (long_hold_req && !hold_taken) begin
                hold_left  = LONG_HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else if (steady_flow) begin
                out_stall <= 1'b0;
            end else if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else if (run_left > 0) begin
                out_stall <= 1'b0;
                run_left--;
            end else begin
                out_stall  <= 1'b0;
                stall_left = pick_gap();
                run_left   = $urandom_range(0, 12);
            end
        end
    end

    // Main stimulus.
    initial begin
        int     sent;
        int     burst_len;
        t_level lvl;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_item  = '0;
        cfg_we   = 1'b0;
        cfg_idx  = '0;
        cfg_data = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset defaults: sample extremes, the threshold edge, bit patterns.
        send_sample(SAMPLE_BITS'(0), 1'b0);
        send_sample(SAMPLE_BITS'(FULL_SCALE - 1), 1'b0);
        send_sample(SAMPLE_BITS'(-FULL_SCALE), 1'b1);
        send_sample(SAMPLE_BITS'(1), 1'b0);
        send_sample(SAMPLE_BITS'(-1), 1'b0);
        send_sample(SAMPLE_BITS'(THRESHOLD_RST), 1'b0);
        send_sample(SAMPLE_BITS'(THRESHOLD_RST + 1), 1'b1);
        send_sample(SAMPLE_BITS'(-(THRESHOLD_RST + 1)), 1'b0);
        send_sample(SAMPLE_BITS'(24'h55_5555), 1'b0);
        send_sample(SAMPLE_BITS'(24'hAA_AAAA), 1'b1);
        drain();

        // Hardest compression; coefficients above one jump the envelope
        // straight to its target both ways.
        set_reg(REG_THRESHOLD, '0);
        set_reg(REG_RATIO,     U16_MAX);
        set_reg(REG_DEPTH,     U16_MAX);
        set_reg(REG_FLOOR,     '0);
        set_reg(REG_ATTACK,    COEF_MAX);
        set_reg(REG_RELEASE,   COEF_MAX);
        send_sample(SAMPLE_BITS'(FULL_SCALE - 1), 1'b0);
        send_sample(SAMPLE_BITS'(-FULL_SCALE), 1'b1);
        send_sample(SAMPLE_BITS'(0), 1'b0);
        send_sample(SAMPLE_BITS'(-FULL_SCALE / 2), 1'b0);
        send_sample(SAMPLE_BITS'(1), 1'b1);
        drain();

        // Threshold and floor above unity, plus writes to unmapped indexes.
        set_reg(REG_THRESHOLD, Q23_MAX);
        set_reg(REG_FLOOR,     Q23_MAX);
        set_reg(IDX_SPARE_LO,  COEF_MAX);
        set_reg(IDX_SPARE_HI,  '0);
        send_sample(SAMPLE_BITS'(-FULL_SCALE), 1'b0);
        send_sample(SAMPLE_BITS'(FULL_SCALE - 1), 1'b1);
        drain();
        set_reg(REG_THRESHOLD, '0);   // floor still above unity
        send_sample(SAMPLE_BITS'(FULL_SCALE - 1), 1'b0);
        send_sample(SAMPLE_BITS'(-FULL_SCALE + 1), 1'b0);
        drain();

        // Random phases, each under its own register setting. Bursts of one
        // level class let the envelope climb and decay.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain();
            random_config();
            steady_flow = (phase == 0);
            if (phase == 2) long_hold_req = 1'b1;   // block fills and stalls its input
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                lvl       = t_level'($urandom_range(LVL_RANDOM, LVL_EXTREME));
                burst_len = $urandom_range(1, 30);
                for (int k = 0; k < burst_len && sent < PHASE_ITEMS; k++) begin
                    send_item(make_item(lvl));
                    sent++;
                    // sender pause until nothing is outstanding
                    if (phase == 4 && sent == PHASE_ITEMS / 2) drain();
                end
            end
        end
        steady_flow = 1'b0;

        drain();
        repeat (END_SLACK) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog.
    initial begin
        #(TIMEOUT_NS);
        $display("TEST FAILED");
        $finish;
    end

endmodule
